>>> rtl/vvau_pkg.sv
// ----------------------------------------------------------------------------
// vvau_pkg
// Types, register indexes, constants and the divider step for the atom update.
// ----------------------------------------------------------------------------
package vvau_pkg;

   typedef struct packed {
      logic               op;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic [15:0]        atom_mass;
      logic               last_atom;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic [31:0]        kinetic_energy;
      logic               range_error;
      logic               last_of_step;
   } rsp_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_Y       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_Z       = 3'd4;

   localparam logic [15:0] TIME_STEP_RST = 16'd4096;
   localparam logic [30:0] BOX_RST       = 31'd1048576;

   // acceleration conversion in Q0.40, half kinetic energy factor in Q.20
   localparam logic [28:0] ACC_Q40 = 29'd460046704;
   localparam logic [30:0] KE_Q20  = 31'd1253078394;

   localparam int DIV_BITS   = 64;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
   localparam int KICK_LAT   = DIV_STAGES + 3;

   typedef struct packed {
      logic [15:0] rem;
      logic [63:0] quo;
   } div_type;

   // restoring division, DIV_STEPS quotient bits
   function automatic div_type div_steps(div_type d, logic [15:0] m);
      div_type     r;
      logic [16:0] t;
      logic        qb;
      r = d;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {r.rem, r.quo[63]};
         if (t >= {1'b0, m}) begin
            qb = 1'b1;
            t  = t - {1'b0, m};
         end else begin
            qb = 1'b0;
         end
         r.rem = t[15:0];
         r.quo = {r.quo[62:0], qb};
      end
      return r;
   endfunction

endpackage

>>> rtl/vvau_kick.sv
// ----------------------------------------------------------------------------
// vvau_kick
// Half kick velocity change F*dt*ACC/(2m) for one axis, pipelined.
// ----------------------------------------------------------------------------
module vvau_kick (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [31:0] force_in,
   input  logic [15:0]        time_step,
   input  logic [15:0]        mass,
   output logic signed [42:0] dv
);

   logic [31:0]        fmag;
   logic [47:0]        p_in;
   logic [47:0]        p_ff;
   logic [15:0]        pm_ff;
   logic               ps_ff;

   vvau_pkg::div_type  div_src [vvau_pkg::DIV_STAGES];
   vvau_pkg::div_type  div_ff  [vvau_pkg::DIV_STAGES];
   logic [15:0]        dm_ff   [vvau_pkg::DIV_STAGES];
   logic               ds_ff   [vvau_pkg::DIV_STAGES];

   logic [60:0]        pl_ff;
   logic [60:0]        ph_ff;
   logic               ms_ff;
   logic [61:0]        mid;
   logic [42:0]        dmag;
   logic signed [42:0] dv_ff;

   assign fmag = force_in[31] ? 32'(-force_in) : 32'(force_in);
   assign p_in = 48'(fmag) * 48'(time_step);

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff  <= p_in;
         pm_ff <= mass;
         ps_ff <= force_in[31];
      end
   end

   always_comb begin
      div_src[0].rem = '0;
      div_src[0].quo = {p_ff, 16'b0};
      for (int g = 1; g < vvau_pkg::DIV_STAGES; g++) begin
         div_src[g] = div_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= vvau_pkg::div_steps(div_src[0], pm_ff);
         dm_ff[0]  <= pm_ff;
         ds_ff[0]  <= ps_ff;
         for (int g = 1; g < vvau_pkg::DIV_STAGES; g++) begin
            div_ff[g] <= vvau_pkg::div_steps(div_src[g], dm_ff[g-1]);
            dm_ff[g]  <= dm_ff[g-1];
            ds_ff[g]  <= ds_ff[g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff <= 61'(div_ff[vvau_pkg::DIV_STAGES-1].quo[31:0]) * 61'(vvau_pkg::ACC_Q40);
         ph_ff <= 61'(div_ff[vvau_pkg::DIV_STAGES-1].quo[63:32]) * 61'(vvau_pkg::ACC_Q40);
         ms_ff <= ds_ff[vvau_pkg::DIV_STAGES-1];
      end
   end

   assign mid  = {1'b0, ph_ff} + {33'b0, pl_ff[60:32]} + 62'd262144;
   assign dmag = mid[61:19];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff <= ms_ff ? -$signed(dmag) : $signed(dmag);
      end
   end

   assign dv = dv_ff;

endmodule

>>> rtl/velocity_verlet_atom_update_core.sv
// Each atom passes the capture register, kick lanes, t1 to t5 and rsp_ff.
// Throughput: one atom per cycle unless rsp_ready stalls; the 16-stage mass
// divider in each kick lane and the stage registers behind it set the depth.
// A stalled result holds every stage in place; nothing is dropped or repeated.
// Reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// velocity_verlet_atom_update_core
// Fixed point velocity Verlet kick, drift, periodic wrap and kinetic energy.
// ----------------------------------------------------------------------------
module velocity_verlet_atom_update_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  vvau_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output vvau_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [vvau_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vvau_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef struct packed {
      logic             op;
      logic             last;
      logic [15:0]      mass;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
   } side_type;

   typedef struct packed {
      logic             op;
      logic             last;
      logic             err;
      logic [15:0]      mass;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] nv;
   } t1_type;

   typedef struct packed {
      logic             op;
      logic             last;
      logic             err;
      logic [15:0]      mass;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] nv;
      logic [2:0][47:0] dprod;
      logic [2:0][63:0] sq;
   } t2_type;

   typedef struct packed {
      logic             op;
      logic             last;
      logic             err;
      logic [15:0]      mass;
      logic [2:0][31:0] nv;
      logic [2:0][33:0] x;
      logic [63:0]      ssum;
   } t3_type;

   typedef struct packed {
      logic             op;
      logic             last;
      logic             err;
      logic [2:0][31:0] nv;
      logic [2:0][33:0] x;
      logic [55:0]      emass;
   } t4_type;

   typedef struct packed {
      logic             op;
      logic             last;
      logic             err;
      logic [2:0][31:0] nv;
      logic [2:0][31:0] np;
      logic [62:0]      pl;
      logic [54:0]      ph;
   } t5_type;

   logic [15:0]        ts_ff;
   logic               wrap_ff;
   logic [2:0][30:0]   box_ff;
   logic [2:0][33:0]   blen;

   logic               adv;
   logic               a_valid_ff;
   vvau_pkg::req_type  a_ff;
   side_type           side_a;
   logic [2:0][31:0]   a_force;
   logic [2:0][42:0]   dv;

   logic               sv_ff   [vvau_pkg::KICK_LAT];
   side_type           side_ff [vvau_pkg::KICK_LAT];

   logic               t1_valid_ff, t2_valid_ff, t3_valid_ff, t4_valid_ff, t5_valid_ff;
   t1_type             t1_in, t1_ff;
   t2_type             t2_in, t2_ff;
   t3_type             t3_in, t3_ff;
   t4_type             t4_in, t4_ff;
   t5_type             t5_in, t5_ff;
   logic               rsp_valid_ff;
   vvau_pkg::rsp_type  rsp_in, rsp_ff;

   logic [43:0]        ksum;
   logic [31:0]        vmag;
   logic [47:0]        rnd;
   logic [27:0]        dx;
   logic [33:0]        dxs;
   logic               derr;
   logic [55:0]        mid;
   logic [45:0]        ke;

   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff   <= vvau_pkg::TIME_STEP_RST;
         wrap_ff <= 1'b0;
         box_ff  <= {3{vvau_pkg::BOX_RST}};
      end else if (csr_we) begin
         case (csr_index)
            vvau_pkg::CSR_TIME_STEP:   ts_ff     <= csr_wdata[15:0];
            vvau_pkg::CSR_WRAP_ENABLE: wrap_ff   <= csr_wdata[0];
            vvau_pkg::CSR_BOX_X:       box_ff[0] <= csr_wdata[30:0];
            vvau_pkg::CSR_BOX_Y:       box_ff[1] <= csr_wdata[30:0];
            vvau_pkg::CSR_BOX_Z:       box_ff[2] <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         blen[i] = (box_ff[i] == '0) ? 34'd1 : {3'b0, box_ff[i]};
      end
   end

   // capture
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= req_data;
      end
   end

   always_comb begin
      side_a.op     = a_ff.op;
      side_a.last   = a_ff.last_atom;
      side_a.mass   = (a_ff.atom_mass == '0) ? 16'd1 : a_ff.atom_mass;
      side_a.pos    = {a_ff.pos_z, a_ff.pos_y, a_ff.pos_x};
      side_a.vel    = {a_ff.vel_z, a_ff.vel_y, a_ff.vel_x};
      a_force       = {a_ff.force_z, a_ff.force_y, a_ff.force_x};
   end

   for (genvar g = 0; g < 3; g++) begin : g_kick
      vvau_kick u_kick (
         .clock     (clock),
         .adv       (adv),
         .force_in  ($signed(a_force[g])),
         .time_step (ts_ff),
         .mass      (side_a.mass),
         .dv        (dv[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < vvau_pkg::KICK_LAT; k++) begin
            sv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         sv_ff[0] <= a_valid_ff;
         for (int k = 1; k < vvau_pkg::KICK_LAT; k++) begin
            sv_ff[k] <= sv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_a;
         for (int k = 1; k < vvau_pkg::KICK_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // kick add and saturate
   always_comb begin
      t1_in.op   = side_ff[vvau_pkg::KICK_LAT-1].op;
      t1_in.last = side_ff[vvau_pkg::KICK_LAT-1].last;
      t1_in.mass = side_ff[vvau_pkg::KICK_LAT-1].mass;
      t1_in.pos  = side_ff[vvau_pkg::KICK_LAT-1].pos;
      t1_in.err  = 1'b0;
      t1_in.nv   = '0;
      ksum       = '0;
      for (int i = 0; i < 3; i++) begin
         ksum = {{12{side_ff[vvau_pkg::KICK_LAT-1].vel[i][31]}},
                 side_ff[vvau_pkg::KICK_LAT-1].vel[i]} + {dv[i][42], dv[i]};
         if (ksum[43:31] == '0 || ksum[43:31] == '1) begin
            t1_in.nv[i] = ksum[31:0];
         end else begin
            t1_in.err   = 1'b1;
            t1_in.nv[i] = ksum[43] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
   end

   // drift and energy products
   always_comb begin
      t2_in.op    = t1_ff.op;
      t2_in.last  = t1_ff.last;
      t2_in.err   = t1_ff.err;
      t2_in.mass  = t1_ff.mass;
      t2_in.pos   = t1_ff.pos;
      t2_in.nv    = t1_ff.nv;
      vmag        = '0;
      for (int i = 0; i < 3; i++) begin
         vmag           = t1_ff.nv[i][31] ? 32'(-t1_ff.nv[i]) : t1_ff.nv[i];
         t2_in.dprod[i] = 48'(vmag) * 48'(ts_ff);
         t2_in.sq[i]    = 64'(vmag) * 64'(vmag);
      end
   end

   // drift add and energy sum; closing kick keeps the position
   always_comb begin
      t3_in.op   = t2_ff.op;
      t3_in.last = t2_ff.last;
      t3_in.err  = t2_ff.err;
      t3_in.mass = t2_ff.mass;
      t3_in.nv   = t2_ff.nv;
      t3_in.ssum = t2_ff.sq[0] + t2_ff.sq[1] + t2_ff.sq[2];
      t3_in.x    = '0;
      rnd        = '0;
      dx         = '0;
      dxs        = '0;
      for (int i = 0; i < 3; i++) begin
         rnd        = t2_ff.dprod[i] + 48'd524288;
         dx         = rnd[47:20];
         dxs        = t2_ff.nv[i][31] ? -{6'b0, dx} : {6'b0, dx};
         if (t2_ff.op) begin
            t3_in.x[i] = {{2{t2_ff.pos[i][31]}}, t2_ff.pos[i]};
         end else begin
            t3_in.x[i] = {{2{t2_ff.pos[i][31]}}, t2_ff.pos[i]} + dxs;
         end
      end
   end

   // first wrap step and mass product
   always_comb begin
      t4_in.op    = t3_ff.op;
      t4_in.last  = t3_ff.last;
      t4_in.err   = t3_ff.err;
      t4_in.nv    = t3_ff.nv;
      t4_in.emass = 56'(t3_ff.mass) * 56'(t3_ff.ssum[63:24]);
      t4_in.x     = t3_ff.x;
      if (wrap_ff && !t3_ff.op) begin
         for (int i = 0; i < 3; i++) begin
            if (t3_ff.x[i][33]) begin
               t4_in.x[i] = t3_ff.x[i] + blen[i];
            end else if ($signed(t3_ff.x[i]) >= $signed(blen[i])) begin
               t4_in.x[i] = t3_ff.x[i] - blen[i];
            end
         end
      end
   end

   // clamp or saturate, energy partial products
   always_comb begin
      t5_in.op   = t4_ff.op;
      t5_in.last = t4_ff.last;
      t5_in.nv   = t4_ff.nv;
      t5_in.pl   = 63'(t4_ff.emass[31:0]) * 63'(vvau_pkg::KE_Q20);
      t5_in.ph   = 55'(t4_ff.emass[55:32]) * 55'(vvau_pkg::KE_Q20);
      t5_in.np   = '0;
      derr       = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (wrap_ff && !t4_ff.op) begin
            if (t4_ff.x[i][33]) begin
               derr        = 1'b1;
               t5_in.np[i] = '0;
            end else if ($signed(t4_ff.x[i]) >= $signed(blen[i])) begin
               derr        = 1'b1;
               t5_in.np[i] = 32'(blen[i] - 34'd1);
            end else begin
               t5_in.np[i] = t4_ff.x[i][31:0];
            end
         end else if (t4_ff.x[i][33:31] == '0 || t4_ff.x[i][33:31] == '1) begin
            t5_in.np[i] = t4_ff.x[i][31:0];
         end else begin
            derr        = 1'b1;
            t5_in.np[i] = t4_ff.x[i][33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
      t5_in.err = t4_ff.err | (~t4_ff.op & derr);
   end

   // energy round, saturate and select by op
   always_comb begin
      mid = {1'b0, t5_ff.ph} + {25'b0, t5_ff.pl[62:32]} + 56'd512;
      ke  = mid[55:10];
      rsp_in.new_pos_x    = t5_ff.np[0];
      rsp_in.new_pos_y    = t5_ff.np[1];
      rsp_in.new_pos_z    = t5_ff.np[2];
      rsp_in.new_vel_x    = t5_ff.nv[0];
      rsp_in.new_vel_y    = t5_ff.nv[1];
      rsp_in.new_vel_z    = t5_ff.nv[2];
      rsp_in.last_of_step = t5_ff.last;
      rsp_in.range_error  = t5_ff.err;
      rsp_in.kinetic_energy = '0;
      if (t5_ff.op) begin
         if (ke[45:32] != '0) begin
            rsp_in.kinetic_energy = 32'hFFFF_FFFF;
            rsp_in.range_error    = 1'b1;
         end else begin
            rsp_in.kinetic_energy = ke[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         t3_valid_ff  <= 1'b0;
         t4_valid_ff  <= 1'b0;
         t5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         t1_valid_ff  <= sv_ff[vvau_pkg::KICK_LAT-1];
         t2_valid_ff  <= t1_valid_ff;
         t3_valid_ff  <= t2_valid_ff;
         t4_valid_ff  <= t3_valid_ff;
         t5_valid_ff  <= t4_valid_ff;
         rsp_valid_ff <= t5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff  <= t1_in;
         t2_ff  <= t2_in;
         t3_ff  <= t3_in;
         t4_ff  <= t4_in;
         t5_ff  <= t5_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams atom records through the velocity Verlet update core under several
// register settings and handshake idling patterns, and checks every result
// against an in-order prediction of kick, drift, wrap and kinetic energy.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;

   class atom_scoreboard;
      vvau_pkg::rsp_type expected_q[$];
      int unsigned       fail_count;
      logic [15:0]       dt;
      logic              wrap_on;
      logic [30:0]       box_len[3];

      function new();
         fail_count = 0;
         dt         = vvau_pkg::TIME_STEP_RST;
         wrap_on    = 1'b0;
         foreach (box_len[i]) box_len[i] = vvau_pkg::BOX_RST;
      endfunction

      function void set_reg(logic [vvau_pkg::CSR_INDEX_W-1:0] idx,
                            logic [vvau_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            vvau_pkg::CSR_TIME_STEP:   dt         = val[15:0];
            vvau_pkg::CSR_WRAP_ENABLE: wrap_on    = val[0];
            vvau_pkg::CSR_BOX_X:       box_len[0] = val;
            vvau_pkg::CSR_BOX_Y:       box_len[1] = val;
            vvau_pkg::CSR_BOX_Z:       box_len[2] = val;
            default: ;
         endcase
      endfunction

      function longint unsigned scaled_round(longint unsigned a, longint unsigned b, int s);
         longint unsigned hi, lo, mid;
         hi  = a >> 32;
         lo  = a & 64'hFFFF_FFFF;
         mid = hi * b + ((lo * b) >> 32);
         mid += 64'd1 << (s - 33);
         return mid >> (s - 32);
      endfunction

      function longint saturate(longint x, inout bit err);
         if (x > 64'sd2147483647) begin
            err = 1'b1;
            return 64'sd2147483647;
         end
         if (x < -64'sd2147483648) begin
            err = 1'b1;
            return -64'sd2147483648;
         end
         return x;
      endfunction

      function longint kick_velocity(longint v, longint f, longint unsigned m, inout bit err);
         longint unsigned mag, p, r;
         longint          dv;
         mag = (f < 0) ? -f : f;
         p   = mag * dt;
         r   = (p << 16) / m;
         dv  = scaled_round(r, vvau_pkg::ACC_Q40, 51);
         if (f < 0) dv = -dv;
         return saturate(v + dv, err);
      endfunction

      function longint drift_position(longint x, longint v, logic [30:0] len, inout bit err);
         longint unsigned mag;
         longint          dx, l;
         mag = (v < 0) ? -v : v;
         dx  = (mag * dt + (64'd1 << 19)) >> 20;
         l   = (len != 0) ? longint'(len) : 1;
         if (v < 0) dx = -dx;
         x += dx;
         if (!wrap_on) return saturate(x, err);
         if (x < 0) x += l;
         else if (x >= l) x -= l;
         if (x < 0) begin
            err = 1'b1;
            x   = 0;
         end else if (x >= l) begin
            err = 1'b1;
            x   = l - 1;
         end
         return x;
      endfunction

      function void note_atom(vvau_pkg::req_type a);
         vvau_pkg::rsp_type r;
         bit                err;
         longint            p[3], v[3], f[3], nv[3], np[3];
         longint unsigned   m, sq, ke, mg;
         err = 1'b0;
         m   = (a.atom_mass == 0) ? 1 : a.atom_mass;
         p[0] = a.pos_x;   p[1] = a.pos_y;   p[2] = a.pos_z;
         v[0] = a.vel_x;   v[1] = a.vel_y;   v[2] = a.vel_z;
         f[0] = a.force_x; f[1] = a.force_y; f[2] = a.force_z;
         for (int i = 0; i < 3; i++) begin
            nv[i] = kick_velocity(v[i], f[i], m, err);
            np[i] = (a.op == 1'b0) ? drift_position(p[i], nv[i], box_len[i], err) : p[i];
         end
         ke = 0;
         if (a.op == 1'b1) begin
            sq = 0;
            for (int i = 0; i < 3; i++) begin
               mg = (nv[i] < 0) ? -nv[i] : nv[i];
               sq += mg * mg;
            end
            ke = scaled_round(m * (sq >> 24), vvau_pkg::KE_Q20, 42);
            if (ke > 64'hFFFF_FFFF) begin
               ke  = 64'hFFFF_FFFF;
               err = 1'b1;
            end
         end
         r.new_pos_x      = np[0][31:0];
         r.new_pos_y      = np[1][31:0];
         r.new_pos_z      = np[2][31:0];
         r.new_vel_x      = nv[0][31:0];
         r.new_vel_y      = nv[1][31:0];
         r.new_vel_z      = nv[2][31:0];
         r.kinetic_energy = ke[31:0];
         r.range_error    = err;
         r.last_of_step   = a.last_atom;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $error("%s: expected %h, actual %h", name, e, a);
            fail_count++;
         end
      endfunction

      function void check_result(vvau_pkg::rsp_type a);
         vvau_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction %h", a);
            fail_count++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("new_pos_x", e.new_pos_x, a.new_pos_x);
         compare_field("new_pos_y", e.new_pos_y, a.new_pos_y);
         compare_field("new_pos_z", e.new_pos_z, a.new_pos_z);
         compare_field("new_vel_x", e.new_vel_x, a.new_vel_x);
         compare_field("new_vel_y", e.new_vel_y, a.new_vel_y);
         compare_field("new_vel_z", e.new_vel_z, a.new_vel_z);
         compare_field("kinetic_energy", e.kinetic_energy, a.kinetic_energy);
         compare_field("range_error", e.range_error, a.range_error);
         compare_field("last_of_step", e.last_of_step, a.last_of_step);
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   vvau_pkg::req_type                req_data;
   logic                             rsp_valid;
   logic                             rsp_ready;
   vvau_pkg::rsp_type                rsp_data;
   logic                             csr_we;
   logic [vvau_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [vvau_pkg::CSR_DATA_W-1:0]  csr_wdata;

   atom_scoreboard    sb;
   vvau_pkg::req_type atom_q[$];
   bit                req_taken;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       quiet_cycles;

   velocity_verlet_atom_update_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_atom(req_data);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // hold an unaccepted transaction, otherwise advance to the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (atom_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_data  <= atom_q.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_csr(logic [vvau_pkg::CSR_INDEX_W-1:0] idx,
                            logic [vvau_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
   endtask

   task automatic end_csr();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (atom_q.size() != 0 || req_valid || sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      case ($urandom_range(4))
         0: w = $urandom;
         1: w = $urandom >> $urandom_range(31);
         2: w = -($urandom >> $urandom_range(31));
         3: w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: w = $urandom_range(255) - 128;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] rand_pos(logic [30:0] len);
      if ($urandom_range(9) < 6 && len != 0) return $urandom % len;
      return rand_word();
   endfunction

   function automatic vvau_pkg::req_type rand_atom();
      vvau_pkg::req_type a;
      a.op        = 1'($urandom_range(1));
      a.pos_x     = rand_pos(sb.box_len[0]);
      a.pos_y     = rand_pos(sb.box_len[1]);
      a.pos_z     = rand_pos(sb.box_len[2]);
      a.vel_x     = rand_word();
      a.vel_y     = rand_word();
      a.vel_z     = rand_word();
      a.force_x   = rand_word();
      a.force_y   = rand_word();
      a.force_z   = rand_word();
      case ($urandom_range(3))
         0: a.atom_mass = $urandom_range(1) ? 16'd0 : 16'hFFFF;
         1: a.atom_mass = 16'($urandom_range(15));
         default: a.atom_mass = 16'($urandom);
      endcase
      a.last_atom = ($urandom_range(15) == 0);
      return a;
   endfunction

   task automatic send_directed();
      vvau_pkg::req_type a;
      for (int k = 0; k < 20; k++) begin
         a = rand_atom();
         a.op        = k[0];
         a.last_atom = k[1];
         case (k / 2)
            0: begin
               a.pos_x = 32'h7FFF_FFFF; a.pos_y = 32'h8000_0000; a.pos_z = 0;
            end
            1: begin
               a.vel_x = 32'h7FFF_FFFF; a.vel_y = 32'h8000_0000; a.vel_z = 0;
            end
            2: begin
               a.force_x = 32'h7FFF_FFFF; a.force_y = 32'h8000_0000; a.force_z = 0;
               a.atom_mass = 16'd1;
            end
            3: a.atom_mass = 16'd0;
            4: a.atom_mass = 16'hFFFF;
            5: begin
               a.vel_x = 32'h7FFF_FFFF; a.vel_y = 32'h7FFF_FFFF; a.vel_z = 32'h8000_0000;
               a.force_x = 32'h7FFF_FFFF; a.force_y = 32'h7FFF_FFFF;
               a.force_z = 32'h8000_0000; a.atom_mass = 16'hFFFF;
            end
            6: begin
               a.vel_x = 0; a.vel_y = 0; a.vel_z = 0;
               a.force_x = 0; a.force_y = 0; a.force_z = 0;
            end
            7: begin
               a.pos_x = -1; a.pos_y = vvau_pkg::BOX_RST; a.pos_z = vvau_pkg::BOX_RST - 1;
            end
            default: ;
         endcase
         atom_q.push_back(a);
      end
   endtask

   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 24;
      recv_idle_pct = 51;
      quiet_cycles  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 24; recv_idle_pct = 51; end
            1: begin send_idle_pct = 51; recv_idle_pct = 24; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            1: begin
               write_csr(vvau_pkg::CSR_TIME_STEP, 31'h0000_FFFF);
               write_csr(vvau_pkg::CSR_WRAP_ENABLE, 31'd1);
               write_csr(vvau_pkg::CSR_BOX_X, 31'd1);
               write_csr(vvau_pkg::CSR_BOX_Y, 31'h7FFF_FFFF);
               write_csr(vvau_pkg::CSR_BOX_Z, 31'd10485760);
               end_csr();
            end
            2: begin
               write_csr(vvau_pkg::CSR_TIME_STEP, 31'd0);
               write_csr(vvau_pkg::CSR_BOX_X, 31'd0);
               write_csr(vvau_pkg::CSR_BOX_Y, 31'd0);
               write_csr(vvau_pkg::CSR_BOX_Z, 31'd0);
               end_csr();
            end
            3: begin
               write_csr(vvau_pkg::CSR_TIME_STEP, 31'd1);
               write_csr(vvau_pkg::CSR_WRAP_ENABLE, 31'd0);
               write_csr(vvau_pkg::CSR_BOX_X, 31'($urandom));
               write_csr(vvau_pkg::CSR_BOX_Y, 31'($urandom));
               write_csr(vvau_pkg::CSR_BOX_Z, 31'($urandom));
               end_csr();
            end
            4: begin
               write_csr(vvau_pkg::CSR_TIME_STEP, 31'($urandom));
               write_csr(vvau_pkg::CSR_WRAP_ENABLE, 31'd1);
               write_csr(vvau_pkg::CSR_BOX_X, 31'($urandom >> $urandom_range(20)));
               write_csr(vvau_pkg::CSR_BOX_Y, 31'($urandom >> $urandom_range(20)));
               write_csr(vvau_pkg::CSR_BOX_Z, 31'($urandom >> $urandom_range(20)));
               end_csr();
            end
            5: begin
               write_csr(vvau_pkg::CSR_TIME_STEP, 31'(vvau_pkg::TIME_STEP_RST));
               write_csr(vvau_pkg::CSR_BOX_X, 31'd8388608);
               write_csr(vvau_pkg::CSR_BOX_Y, 31'd8388608);
               write_csr(vvau_pkg::CSR_BOX_Z, 31'd8388608);
               end_csr();
            end
            default: ;
         endcase
         if (phase == 0 || phase == 1) send_directed();
         for (int n = 0; n < 300; n++) atom_q.push_back(rand_atom());
         wait_idle();
      end

      if (sb.fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
